// ===== rtl/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants of the sparse polynomial multiplier
// Term widths, opcodes, sequencer states and the term record that moves
// along the sorting chain.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int TERMS_PER_POLY = 8;
  localparam int IDX_W          = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
  localparam int CNT_W          = IDX_W + 1;

  localparam int COEF_W = 16;
  localparam int EXP_W  = 8;
  localparam int SUM_W  = 38;
  localparam int PEXP_W = EXP_W + 1;
  localparam int PROD_W = 2 * COEF_W;

  // one cell for every possible product term
  localparam int CELLS  = TERMS_PER_POLY * TERMS_PER_POLY;
  localparam int FLUSH_CYCLES = CELLS + 2;
  localparam int FL_W   = $clog2(FLUSH_CYCLES + 1);

  typedef enum logic [1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_COMPUTE     = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MULT  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  typedef struct packed {
    logic                     vld;
    logic signed [SUM_W-1:0]  coef;
    logic        [PEXP_W-1:0] expo;
  } term_t;

endpackage

// ===== rtl/spm_req_if.sv =====
// ----------------------------------------------------------------------------
// spm_req_if: request channel
// Valid/ready channel carrying one load or compute item.
// ----------------------------------------------------------------------------
interface spm_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         opcode;
  logic signed [spm_pkg::COEF_W-1:0]  coefficient;
  logic        [spm_pkg::EXP_W-1:0]   exponent;

  modport source (output valid, opcode, coefficient, exponent, input ready);
  modport sink   (input valid, opcode, coefficient, exponent, output ready);
endinterface

// ===== rtl/spm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spm_rsp_if: result channel
// Valid/ready channel carrying one product term.
// ----------------------------------------------------------------------------
interface spm_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [spm_pkg::SUM_W-1:0]  product_coefficient;
  logic        [spm_pkg::PEXP_W-1:0] product_exponent;
  logic                              last_term;
  logic                              empty_result;
  logic                              terms_dropped;

  modport source (output valid, product_coefficient, product_exponent, last_term,
                  empty_result, terms_dropped, input ready);
  modport sink   (input valid, product_coefficient, product_exponent, last_term,
                  empty_result, terms_dropped, output ready);
endinterface

// ===== rtl/spm_cell.sv =====
// ----------------------------------------------------------------------------
// spm_cell: one slot of the sorted product table
// Holds one term; an incoming term is merged, swapped in or passed on so
// that the chain stays in descending exponent order. In shift mode the cell
// takes the term of its downstream neighbor.
// ----------------------------------------------------------------------------
module spm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  spm_pkg::term_t carry_i,
  input  spm_pkg::term_t next_i,
  output spm_pkg::term_t carry_o,
  output spm_pkg::term_t term_o
);

  spm_pkg::term_t term_q, term_d;
  spm_pkg::term_t carry_q, carry_d;

  always_comb begin
    term_d  = term_q;
    carry_d = carry_i;
    carry_d.vld = 1'b0;
    if (shift_i) begin
      term_d = next_i;
    end else if (carry_i.vld) begin
      priority if (!term_q.vld) begin
        term_d = carry_i;
      end else if (term_q.expo == carry_i.expo) begin
        term_d.coef = term_q.coef + carry_i.coef;
      end else if (term_q.expo < carry_i.expo) begin
        // take the higher exponent, push the old one down the chain
        term_d  = carry_i;
        carry_d = term_q;
      end else begin
        carry_d = carry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q  <= '0;
      carry_q <= '0;
    end else begin
      term_q  <= term_d;
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;
  assign term_o  = term_q;

endmodule

// ===== rtl/spm_chain.sv =====
// ----------------------------------------------------------------------------
// spm_chain: systolic sorted table
// A row of cells; products enter at the head one per cycle and settle in
// descending exponent order. Shift mode moves the table out through the head.
// ----------------------------------------------------------------------------
module spm_chain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  spm_pkg::term_t inject_i,
  output spm_pkg::term_t head_o,
  output spm_pkg::term_t tail_o
);

  spm_pkg::term_t carry [spm_pkg::CELLS+1];
  spm_pkg::term_t stored [spm_pkg::CELLS+1];

  assign carry[0]                = inject_i;
  assign stored[spm_pkg::CELLS]  = '0;

  for (genvar k = 0; k < spm_pkg::CELLS; k++) begin : g_cell
    spm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_i),
      .carry_i (carry[k]),
      .next_i  (stored[k+1]),
      .carry_o (carry[k+1]),
      .term_o  (stored[k])
    );
  end

  assign head_o = stored[0];
  assign tail_o = carry[spm_pkg::CELLS];

endmodule

// ===== rtl/sparse_polynomial_multiply.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_multiply: sparse polynomial multiplier
// Sequence: a load writes its term store directly. A compute feeds all Na*Nb
//   products into the chain, waits in the flush state for the chain to settle,
//   then shifts the table out through the head cell and emits the final term,
//   with output stalls holding the drain; a picked term is presented in the next cycle.
// Throughput: one item at a time; results leave at up to one per cycle while the result side is ready.
// Reset: clears load counts, drop flag, the cells and the output valid bit;
//   the term stores and output data hold whatever was last written.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiply (
  input  logic       clk_i,
  input  logic       rst_ni,
  spm_req_if.sink    req_i,
  spm_rsp_if.source  rsp_o
);

  // term stores
  logic signed [spm_pkg::COEF_W-1:0] a_coef_q [spm_pkg::TERMS_PER_POLY];
  logic        [spm_pkg::EXP_W-1:0]  a_exp_q  [spm_pkg::TERMS_PER_POLY];
  logic signed [spm_pkg::COEF_W-1:0] b_coef_q [spm_pkg::TERMS_PER_POLY];
  logic        [spm_pkg::EXP_W-1:0]  b_exp_q  [spm_pkg::TERMS_PER_POLY];

  logic [spm_pkg::CNT_W-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic                      ovf_q, ovf_d;
  logic [spm_pkg::IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic [spm_pkg::FL_W-1:0]  fl_q, fl_d;
  spm_pkg::state_e           state_q, state_d;

  spm_pkg::term_t prod_q, prod_d;
  spm_pkg::term_t hold_q, hold_d;
  spm_pkg::term_t head, tail;
  logic           shift;

  logic                              out_vld_q, out_vld_d;
  logic signed [spm_pkg::SUM_W-1:0]  out_coef_q, out_coef_d;
  logic        [spm_pkg::PEXP_W-1:0] out_exp_q, out_exp_d;
  logic                              out_last_q, out_last_d;
  logic                              out_empty_q, out_empty_d;
  logic                              out_drop_q, out_drop_d;

  logic                               req_xfer, slot_free, emit, a_wr, b_wr;
  logic signed [spm_pkg::PROD_W-1:0]  mul;
  spm_pkg::op_e                       op;

  assign req_i.ready = (state_q == spm_pkg::ST_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign op          = spm_pkg::op_e'(req_i.opcode);
  assign slot_free   = !out_vld_q || rsp_o.ready;

  assign mul = a_coef_q[i_q] * b_coef_q[j_q];

  spm_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .inject_i (prod_q),
    .head_o   (head),
    .tail_o   (tail)
  );

  always_comb begin
    state_d  = state_q;
    a_cnt_d  = a_cnt_q;
    b_cnt_d  = b_cnt_q;
    ovf_d    = ovf_q;
    i_d      = i_q;
    j_d      = j_q;
    fl_d     = fl_q;
    a_wr     = 1'b0;
    b_wr     = 1'b0;
    shift    = 1'b0;
    hold_d   = hold_q;
    emit     = 1'b0;
    prod_d   = prod_q;
    prod_d.vld = 1'b0;

    out_coef_d  = out_coef_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_drop_d  = out_drop_q;

    unique case (state_q)
      spm_pkg::ST_IDLE: begin
        if (req_xfer) begin
          unique case (op)
            spm_pkg::OP_LOAD_FIRST: begin
              if (a_cnt_q < spm_pkg::CNT_W'(spm_pkg::TERMS_PER_POLY)) begin
                a_wr    = 1'b1;
                a_cnt_d = a_cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            spm_pkg::OP_LOAD_SECOND: begin
              if (b_cnt_q < spm_pkg::CNT_W'(spm_pkg::TERMS_PER_POLY)) begin
                b_wr    = 1'b1;
                b_cnt_d = b_cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            spm_pkg::OP_COMPUTE: begin
              i_d  = '0;
              j_d  = '0;
              fl_d = '0;
              if (a_cnt_q != '0 && b_cnt_q != '0) begin
                state_d = spm_pkg::ST_MULT;
              end else begin
                state_d = spm_pkg::ST_FLUSH;
              end
            end
            default: ;  // unused opcode: drop
          endcase
        end
      end

      spm_pkg::ST_MULT: begin
        prod_d.vld  = 1'b1;
        prod_d.coef = spm_pkg::SUM_W'(mul);
        prod_d.expo = {1'b0, a_exp_q[i_q]} + {1'b0, b_exp_q[j_q]};
        if ({1'b0, j_q} == b_cnt_q - 1'b1) begin
          j_d = '0;
          if ({1'b0, i_q} == a_cnt_q - 1'b1) begin
            state_d = spm_pkg::ST_FLUSH;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      spm_pkg::ST_FLUSH: begin
        // wait until every product has settled in its cell
        if (fl_q == spm_pkg::FL_W'(spm_pkg::FLUSH_CYCLES)) begin
          state_d = spm_pkg::ST_DRAIN;
        end else begin
          fl_d = fl_q + 1'b1;
        end
      end

      spm_pkg::ST_DRAIN: begin
        if (head.vld) begin
          if (head.coef == '0) begin
            shift = 1'b1;
          end else if (!hold_q.vld) begin
            shift  = 1'b1;
            hold_d = head;
          end else if (slot_free) begin
            // a later nonzero term exists, so the held one is not last
            shift       = 1'b1;
            emit        = 1'b1;
            out_coef_d  = hold_q.coef;
            out_exp_d   = hold_q.expo;
            out_last_d  = 1'b0;
            out_empty_d = 1'b0;
            out_drop_d  = ovf_q;
            hold_d      = head;
          end
        end else if (slot_free) begin
          emit        = 1'b1;
          out_last_d  = 1'b1;
          out_drop_d  = ovf_q;
          if (hold_q.vld) begin
            out_coef_d  = hold_q.coef;
            out_exp_d   = hold_q.expo;
            out_empty_d = 1'b0;
          end else begin
            out_coef_d  = '0;
            out_exp_d   = '0;
            out_empty_d = 1'b1;
          end
          hold_d.vld = 1'b0;
          a_cnt_d    = '0;
          b_cnt_d    = '0;
          ovf_d      = 1'b0;
          state_d    = spm_pkg::ST_IDLE;
        end
      end

      default: state_d = spm_pkg::ST_IDLE;
    endcase

    if (emit) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spm_pkg::ST_IDLE;
      a_cnt_q   <= '0;
      b_cnt_q   <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      fl_q      <= '0;
      prod_q    <= '0;
      hold_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      a_cnt_q   <= a_cnt_d;
      b_cnt_q   <= b_cnt_d;
      ovf_q     <= ovf_d;
      i_q       <= i_d;
      j_q       <= j_d;
      fl_q      <= fl_d;
      prod_q    <= prod_d;
      hold_q    <= hold_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      a_coef_q[a_cnt_q[spm_pkg::IDX_W-1:0]] <= req_i.coefficient;
      a_exp_q[a_cnt_q[spm_pkg::IDX_W-1:0]]  <= req_i.exponent;
    end
    if (b_wr) begin
      b_coef_q[b_cnt_q[spm_pkg::IDX_W-1:0]] <= req_i.coefficient;
      b_exp_q[b_cnt_q[spm_pkg::IDX_W-1:0]]  <= req_i.exponent;
    end
    out_coef_q  <= out_coef_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_drop_q  <= out_drop_d;
  end

  assign rsp_o.valid               = out_vld_q;
  assign rsp_o.product_coefficient = out_coef_q;
  assign rsp_o.product_exponent    = out_exp_q;
  assign rsp_o.last_term           = out_last_q;
  assign rsp_o.empty_result        = out_empty_q;
  assign rsp_o.terms_dropped       = out_drop_q;

  // the table never holds more distinct exponents than it has cells
  a_no_tail_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tail.vld) else $error("product term left the end of the chain");

  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.empty_result) |->
      (rsp_o.last_term && rsp_o.product_coefficient == '0))
    else $error("empty result not a final zero term");

  a_nonempty_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.empty_result) |-> (rsp_o.product_coefficient != '0))
    else $error("zero coefficient emitted as a product term");

  a_final_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last_d) |=> (state_q == spm_pkg::ST_IDLE && a_cnt_q == '0 && !ovf_q))
    else $error("final transfer did not return to idle with counts cleared");

endmodule

// ===== tb/tb_sparse_polynomial_multiply.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_multiply: self-checking bench for the sparse multiplier
// Loads term pairs over the request channel and issues computes. A scoreboard
// forms the expected product terms for every accepted compute and checks the
// result channel term by term. Both channels idle at random, the result side
// holds off for a long stretch once, and the term stores are overrun.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_multiply;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET = 280;
  localparam int         TABLE_SIZE  = spm_pkg::CELLS;
  localparam int         MAX_SHOWN   = 10;

  typedef struct packed {
    logic signed [spm_pkg::SUM_W-1:0]  coef;
    logic        [spm_pkg::PEXP_W-1:0] expo;
    logic                              last;
    logic                              empty;
    logic                              dropped;
  } product_term_t;

  class term_scoreboard;
    logic signed [spm_pkg::COEF_W-1:0] a_coef[spm_pkg::TERMS_PER_POLY];
    logic        [spm_pkg::EXP_W-1:0]  a_expo[spm_pkg::TERMS_PER_POLY];
    logic signed [spm_pkg::COEF_W-1:0] b_coef[spm_pkg::TERMS_PER_POLY];
    logic        [spm_pkg::EXP_W-1:0]  b_expo[spm_pkg::TERMS_PER_POLY];
    int                       a_cnt;
    int                       b_cnt;
    bit                       dropped;
    product_term_t            pending_terms[$];
    int                       errors;
    int                       checked;
    int                       computes;

    function new();
      a_cnt    = 0;
      b_cnt    = 0;
      dropped  = 0;
      errors   = 0;
      checked  = 0;
      computes = 0;
    endfunction

    function int pending();
      return pending_terms.size();
    endfunction

    // Form every pairwise product, merge equal exponents in descending order,
    // then queue the nonzero sums, or a single empty term when none is nonzero.
    function void multiply_polys();
      longint                     sum[TABLE_SIZE];
      logic [spm_pkg::PEXP_W-1:0] ex[TABLE_SIZE];
      longint                     p;
      logic [spm_pkg::PEXP_W-1:0] x;
      int                         n;
      int                         pos;
      int                         last_idx;
      product_term_t              t;
      n = 0;
      for (int i = 0; i < a_cnt; i++) begin
        for (int j = 0; j < b_cnt; j++) begin
          p = longint'(a_coef[i]) * longint'(b_coef[j]);
          x = {1'b0, a_expo[i]} + {1'b0, b_expo[j]};
          pos = 0;
          while (pos < n && ex[pos] > x) pos++;
          if (pos < n && ex[pos] == x) begin
            sum[pos] += p;
          end else begin
            for (int k = n; k > pos; k--) begin
              sum[k] = sum[k-1];
              ex[k]  = ex[k-1];
            end
            sum[pos] = p;
            ex[pos]  = x;
            n++;
          end
        end
      end
      last_idx = -1;
      for (int i = 0; i < n; i++)
        if (sum[i] != 0) last_idx = i;
      if (last_idx < 0) begin
        t = '{coef: '0, expo: '0, last: 1'b1, empty: 1'b1, dropped: dropped};
        pending_terms.push_back(t);
      end else begin
        for (int i = 0; i <= last_idx; i++) begin
          if (sum[i] != 0) begin
            t.coef    = sum[i][spm_pkg::SUM_W-1:0];
            t.expo    = ex[i];
            t.last    = (i == last_idx);
            t.empty   = 1'b0;
            t.dropped = dropped;
            pending_terms.push_back(t);
          end
        end
      end
      a_cnt    = 0;
      b_cnt    = 0;
      dropped  = 0;
      computes++;
    endfunction

    function void note_item(logic [1:0] op, logic signed [spm_pkg::COEF_W-1:0] c,
                            logic [spm_pkg::EXP_W-1:0] e);
      case (op)
        spm_pkg::OP_LOAD_FIRST: begin
          if (a_cnt < spm_pkg::TERMS_PER_POLY) begin
            a_coef[a_cnt] = c;
            a_expo[a_cnt] = e;
            a_cnt++;
          end else begin
            dropped = 1;
          end
        end
        spm_pkg::OP_LOAD_SECOND: begin
          if (b_cnt < spm_pkg::TERMS_PER_POLY) begin
            b_coef[b_cnt] = c;
            b_expo[b_cnt] = e;
            b_cnt++;
          end else begin
            dropped = 1;
          end
        end
        spm_pkg::OP_COMPUTE: multiply_polys();
        default: ;
      endcase
    endfunction

    function void check_term(product_term_t got);
      product_term_t want;
      if (pending_terms.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected term: coef %0d exp %0d last %0b empty %0b dropped %0b",
                   got.coef, got.expo, got.last, got.empty, got.dropped);
        return;
      end
      want = pending_terms.pop_front();
      checked++;
      if (got.coef !== want.coef || got.expo !== want.expo || got.last !== want.last ||
          got.empty !== want.empty || got.dropped !== want.dropped) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("term mismatch at %0t", $realtime);
          $display("  expected coef %0d exp %0d last %0b empty %0b dropped %0b",
                   want.coef, want.expo, want.last, want.empty, want.dropped);
          $display("  actual   coef %0d exp %0d last %0b empty %0b dropped %0b",
                   got.coef, got.expo, got.last, got.empty, got.dropped);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  spm_req_if req_if ();
  spm_rsp_if rsp_if ();

  sparse_polynomial_multiply i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  term_scoreboard sb = new();

  int items_sent = 0;
  bit tx_steady  = 0;
  bit rx_steady  = 0;
  bit hold_off_req = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("simulation failed");
    $finish;
  end

  // Result side: check each transfer, then pick ready for the next cycle.
  initial begin : result_sink
    int hold_left;
    int unsigned r;
    product_term_t got;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        got.coef    = rsp_if.product_coefficient;
        got.expo    = rsp_if.product_exponent;
        got.last    = rsp_if.last_term;
        got.empty   = rsp_if.empty_result;
        got.dropped = rsp_if.terms_dropped;
        sb.check_term(got);
      end
      if (hold_off_req) begin
        hold_off_req = 0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (rx_steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rsp_if.ready <= 1'b1;
        end else if (r < 95) begin
          rsp_if.ready <= 1'b0;
          hold_left = $urandom_range(0, 3);
        end else begin
          rsp_if.ready <= 1'b0;
          hold_left = $urandom_range(10, 60);
        end
      end
    end
  end

  function automatic int gap_len();
    int unsigned r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic int pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 60) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(4, 6);
    if (r < 95) return $urandom_range(7, 8);
    return $urandom_range(9, 11);
  endfunction

  function automatic logic signed [spm_pkg::COEF_W-1:0] rand_coef(int mode);
    int v;
    case (mode)
      1: begin
        v = int'($urandom_range(0, 6)) - 3;
        return v[spm_pkg::COEF_W-1:0];
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return spm_pkg::COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [spm_pkg::EXP_W-1:0] rand_expo(int mode);
    case (mode)
      1: return spm_pkg::EXP_W'($urandom_range(0, 7));
      2: return spm_pkg::EXP_W'($urandom_range(248, 255));
      default: return spm_pkg::EXP_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic idle(int n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one item, hold it until the transfer, then leave a random gap.
  task automatic send_item(logic [1:0] op, logic signed [spm_pkg::COEF_W-1:0] c,
                           logic [spm_pkg::EXP_W-1:0] e);
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.coefficient <= c;
    req_if.exponent    <= e;
    do @(posedge clk); while (!req_if.ready);
    sb.note_item(op, c, e);
    if (op != OP_UNUSED) items_sent++;
    idle(gap_len());
  endtask

  // Drop valid and hold until every expected term has been checked.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Load both polynomials in random interleave, then compute.
  task automatic run_poly(int na, int nb, int cmode, int emode);
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 0)) begin
        send_item(spm_pkg::OP_LOAD_FIRST, rand_coef(cmode), rand_expo(emode));
        ia++;
      end else begin
        send_item(spm_pkg::OP_LOAD_SECOND, rand_coef(cmode), rand_expo(emode));
        ib++;
      end
    end
    send_item(spm_pkg::OP_COMPUTE, spm_pkg::COEF_W'($urandom), spm_pkg::EXP_W'($urandom));
  endtask

  task automatic noise_burst();
    int n;
    int unsigned r;
    logic [1:0] op;
    n = $urandom_range(4, 12);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      op = (r < 4) ? spm_pkg::OP_LOAD_FIRST : (r < 8) ? spm_pkg::OP_LOAD_SECOND :
           (r < 9) ? spm_pkg::OP_COMPUTE : OP_UNUSED;
      send_item(op, spm_pkg::COEF_W'($urandom), spm_pkg::EXP_W'($urandom));
    end
  endtask

  initial begin : stimulus
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.opcode      <= spm_pkg::OP_LOAD_FIRST;
    req_if.coefficient <= '0;
    req_if.exponent    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing loaded: single empty term
    send_item(spm_pkg::OP_COMPUTE, 16'sh7fff, 8'hff);
    // field extremes, including the top product exponent
    send_item(spm_pkg::OP_LOAD_FIRST, 16'sh8000, 8'hff);
    send_item(spm_pkg::OP_LOAD_SECOND, 16'sh8000, 8'hff);
    send_item(spm_pkg::OP_LOAD_FIRST, 16'sh7fff, 8'h00);
    send_item(spm_pkg::OP_LOAD_SECOND, 16'sh7fff, 8'h00);
    send_item(spm_pkg::OP_COMPUTE, 16'sh0000, 8'h00);
    // lowest exponent cancels: last flag moves up to the x term
    send_item(spm_pkg::OP_LOAD_FIRST, 16'sd1, 8'd1);
    send_item(spm_pkg::OP_LOAD_FIRST, 16'sd1, 8'd0);
    send_item(spm_pkg::OP_LOAD_SECOND, 16'sd1, 8'd1);
    send_item(spm_pkg::OP_LOAD_SECOND, 16'sd1, 8'd0);
    send_item(spm_pkg::OP_LOAD_SECOND, -16'sd1, 8'd0);
    // unused opcode must leave the loaded terms alone
    send_item(OP_UNUSED, 16'sh5a5a, 8'ha5);
    send_item(spm_pkg::OP_COMPUTE, 16'sh0000, 8'h00);
    // second store overrun
    send_item(spm_pkg::OP_LOAD_FIRST, -16'sd3, 8'd2);
    for (int i = 0; i < spm_pkg::TERMS_PER_POLY + 1; i++)
      send_item(spm_pkg::OP_LOAD_SECOND, rand_coef(0), 8'(i * 3));
    send_item(spm_pkg::OP_COMPUTE, 16'sh0000, 8'h00);
    wait_drained();

    // Hold off the result side while a full 8x8 product and a worst-case
    // overrun sum queue up behind it.
    hold_off_req = 1;
    for (int i = 0; i < spm_pkg::TERMS_PER_POLY; i++) begin
      send_item(spm_pkg::OP_LOAD_FIRST, rand_coef(0), 8'(i * spm_pkg::TERMS_PER_POLY));
      send_item(spm_pkg::OP_LOAD_SECOND, rand_coef(0), 8'(i));
    end
    send_item(spm_pkg::OP_COMPUTE, spm_pkg::COEF_W'($urandom), spm_pkg::EXP_W'($urandom));
    for (int i = 0; i < spm_pkg::TERMS_PER_POLY + 1; i++) begin
      send_item(spm_pkg::OP_LOAD_FIRST, 16'sh8000, 8'hff);
      send_item(spm_pkg::OP_LOAD_SECOND, 16'sh8000, 8'hff);
    end
    send_item(spm_pkg::OP_COMPUTE, spm_pkg::COEF_W'($urandom), spm_pkg::EXP_W'($urandom));
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 7) == 0);
      rx_steady = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0)
        noise_burst();
      else
        run_poly(pick_size(), pick_size(), $urandom_range(0, 2), $urandom_range(0, 2));
      if ($urandom_range(0, 6) == 0) wait_drained();
    end
    tx_steady = 0;
    rx_steady = 0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.pending() != 0) sb.errors++;

    $display("covered %0d accepted items and %0d computes, %0d product terms checked",
             items_sent, sb.computes, sb.checked);
    $display("failures: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
